FILE: rtl/core/nop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nop_pkg: shared types for the note pairing block
// Payload structs of both channels, slot contents and per-cell control.
// ----------------------------------------------------------------------------
package nop_pkg;

  localparam int KeyW   = 7;
  localparam int VelW   = 7;
  localparam int TickW  = 32;
  localparam int DeltaW = 28;
  localparam int ActW   = 2;

  localparam logic [KeyW-1:0] KEY_MAX = 7'd127;
  localparam logic [KeyW-1:0] KEY_MIN = 7'd0;

  // Code 3 is unused and behaves like ACT_OTHER.
  typedef enum logic [ActW-1:0] {
    ACT_OTHER = 2'd0,
    ACT_ON    = 2'd1,
    ACT_OFF   = 2'd2
  } action_e;

  typedef struct packed {
    logic              new_track;
    logic [DeltaW-1:0] delta_ticks;
    logic [ActW-1:0]   action;
    logic [KeyW-1:0]   note_key;
    logic [VelW-1:0]   note_velocity;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0]  done_key;
    logic [VelW-1:0]  done_velocity;
    logic [TickW-1:0] start_tick;
    logic [TickW-1:0] length_ticks;
    logic [KeyW-1:0]  track_lowest;
    logic [KeyW-1:0]  track_highest;
    logic [KeyW-1:0]  song_lowest;
    logic [KeyW-1:0]  song_highest;
    logic             table_overflow;
  } out_item_t;

  typedef struct packed {
    logic             used;
    logic [KeyW-1:0]  key;
    logic [VelW-1:0]  velocity;
    logic [TickW-1:0] start;
  } slot_t;

  // Broadcast to every cell for the request being taken.
  typedef struct packed {
    logic             en;
    logic             clear;
    logic             push;
    logic             pull;
    logic [KeyW-1:0]  key;
    logic [VelW-1:0]  velocity;
    logic [TickW-1:0] start;
  } cell_ctl_t;

endpackage

FILE: rtl/core/nop_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nop_in_if: event request channel
// Valid/ready handshake carrying one classified note event.
// ----------------------------------------------------------------------------
interface nop_in_if;
  logic              valid;
  logic              ready;
  nop_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/nop_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nop_out_if: completed note channel
// Valid/ready handshake carrying one paired note with its statistics.
// ----------------------------------------------------------------------------
interface nop_out_if;
  logic               valid;
  logic               ready;
  nop_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/nop_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nop_cell: one slot of the sounding-note table
// Holds one entry, matches it against a note-off, takes its right neighbor's
// entry when the table closes a gap, and takes a note-on when it is the
// first free slot.
// ----------------------------------------------------------------------------
module nop_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nop_pkg::cell_ctl_t ctl_i,
  input  logic              prev_used_i,
  input  nop_pkg::slot_t    next_i,
  input  logic              hit_i,
  input  nop_pkg::slot_t    found_i,
  output nop_pkg::slot_t    slot_o,
  output logic              hit_o,
  output nop_pkg::slot_t    found_o
);

  logic                          used_q, used_d;
  logic [nop_pkg::KeyW-1:0]      key_q;
  logic [nop_pkg::VelW-1:0]      vel_q;
  logic [nop_pkg::TickW-1:0]     start_q;
  nop_pkg::slot_t                cur;
  nop_pkg::slot_t                nxt;
  logic                          match;

  // new_track empties the table before the event applies
  always_comb begin
    cur.used     = used_q & ~ctl_i.clear;
    cur.key      = key_q;
    cur.velocity = vel_q;
    cur.start    = start_q;
  end

  assign match   = ctl_i.pull & cur.used & (key_q == ctl_i.key);
  assign hit_o   = hit_i | match;
  assign found_o = found_i | ((match & ~hit_i) ? cur : '0);
  assign slot_o  = cur;

  always_comb begin
    nxt = cur;
    if (hit_o) begin
      nxt = next_i;
    end else if (ctl_i.push & ~cur.used & prev_used_i) begin
      nxt.used     = 1'b1;
      nxt.key      = ctl_i.key;
      nxt.velocity = ctl_i.velocity;
      nxt.start    = ctl_i.start;
    end
  end

  assign used_d = ctl_i.en ? nxt.used : used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      key_q   <= nxt.key;
      vel_q   <= nxt.velocity;
      start_q <= nxt.start;
    end
  end

endmodule

FILE: rtl/core/note_on_off_pairing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_on_off_pairing: pairs note-on and note-off events into notes
// A chain of SLOTS cells keeps the sounding notes oldest first with no gaps.
// A matched note-off removes its entry and yields the note with its length
// and the running track and song key extremes.
// ----------------------------------------------------------------------------
//
//   channel | dir | request carries
//   --------+-----+-------------------------------------------------------
//   evt_i   | in  | new_track, delta_ticks, action, note_key, note_velocity
//   note_o  | out | key, velocity, start, length, key extremes, overflow
//
// Flow: every cell compares and shifts in the same cycle as an event is taken.
//   A matched note-off then waits in a pending register before the output
//   register, and the length subtract is done as it moves into that register.
// Reset: rst_ni clears the slot valid bits, clock, extremes and flags at once;
//   no clearing pass is needed.
// Stalls: evt_i.ready is low while a note waits in the pending register, and
//   also for as long as note_o.ready low holds the output register.
// ----------------------------------------------------------------------------
module note_on_off_pairing #(
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nop_in_if.sink      evt_i,
  nop_out_if.source   note_o
);

  // --------------------------------------------------------------------------
  // Event decode
  // --------------------------------------------------------------------------
  logic                        acc;
  logic                        is_on, is_off;
  logic                        nt;
  logic [nop_pkg::TickW-1:0]   clk_q, clk_base, clk_new;

  assign acc    = evt_i.valid & evt_i.ready;
  assign nt     = evt_i.data.new_track;
  assign is_on  = (evt_i.data.action == nop_pkg::ACT_ON);
  assign is_off = (evt_i.data.action == nop_pkg::ACT_OFF);

  // clock restarts at zero on new_track, then the delta is added
  assign clk_base = nt ? '0 : clk_q;
  assign clk_new  = clk_base
                  + {{(nop_pkg::TickW - nop_pkg::DeltaW){1'b0}}, evt_i.data.delta_ticks};

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  nop_pkg::cell_ctl_t ctl;
  nop_pkg::slot_t     slot_c  [SLOTS];
  nop_pkg::slot_t     found_c [SLOTS+1];
  logic               hit_c   [SLOTS+1];
  logic [SLOTS-1:0]   used_vec;

  always_comb begin
    ctl.en       = acc;
    ctl.clear    = nt;
    ctl.push     = is_on;
    ctl.pull     = is_off;
    ctl.key      = evt_i.data.note_key;
    ctl.velocity = evt_i.data.note_velocity;
    ctl.start    = clk_new;
  end

  assign hit_c[0]   = 1'b0;
  assign found_c[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic           prev_used;
    nop_pkg::slot_t next_slot;

    if (i == 0) begin : g_head
      assign prev_used = 1'b1;
    end else begin : g_body
      assign prev_used = slot_c[i-1].used;
    end

    // last cell pulls in an empty entry when the table closes up
    if (i == SLOTS - 1) begin : g_tail
      assign next_slot = '0;
    end else begin : g_link
      assign next_slot = slot_c[i+1];
    end

    nop_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .prev_used_i (prev_used),
      .next_i      (next_slot),
      .hit_i       (hit_c[i]),
      .found_i     (found_c[i]),
      .slot_o      (slot_c[i]),
      .hit_o       (hit_c[i+1]),
      .found_o     (found_c[i+1])
    );

    assign used_vec[i] = slot_c[i].used;
  end

  logic           hit_any, full;
  nop_pkg::slot_t found;

  assign hit_any = hit_c[SLOTS];
  assign found   = found_c[SLOTS];
  assign full    = slot_c[SLOTS-1].used;

  // --------------------------------------------------------------------------
  // Clock, key extremes, overflow flag
  // --------------------------------------------------------------------------
  logic [nop_pkg::KeyW-1:0] tl_q, th_q, sl_q, sh_q;
  logic [nop_pkg::KeyW-1:0] tl_b, th_b, tl_d, th_d, sl_d, sh_d;
  logic                     ovf_q, ovf_d;
  logic                     emit;

  assign emit = acc & is_off & hit_any;
  assign tl_b = nt ? nop_pkg::KEY_MAX : tl_q;
  assign th_b = nt ? nop_pkg::KEY_MIN : th_q;

  always_comb begin
    tl_d = tl_b;
    th_d = th_b;
    sl_d = sl_q;
    sh_d = sh_q;
    if (emit) begin
      if (found.key < tl_b) tl_d = found.key;
      if (found.key > th_b) th_d = found.key;
      if (found.key < sl_q) sl_d = found.key;
      if (found.key > sh_q) sh_d = found.key;
    end
  end

  // sticky, survives new_track
  assign ovf_d = ovf_q | (acc & is_on & full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q <= '0;
      tl_q  <= nop_pkg::KEY_MAX;
      th_q  <= nop_pkg::KEY_MIN;
      sl_q  <= nop_pkg::KEY_MAX;
      sh_q  <= nop_pkg::KEY_MIN;
      ovf_q <= 1'b0;
    end else begin
      ovf_q <= ovf_d;
      if (acc) begin
        clk_q <= clk_new;
        tl_q  <= tl_d;
        th_q  <= th_d;
        sl_q  <= sl_d;
        sh_q  <= sh_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pending note, then output register
  // --------------------------------------------------------------------------
  logic                      pend_q, pend_d;
  logic                      out_vld_q, out_vld_d;
  logic                      out_free, move;
  nop_pkg::slot_t            pend_slot_q;
  logic [nop_pkg::TickW-1:0] pend_end_q;
  logic [nop_pkg::KeyW-1:0]  pend_tl_q, pend_th_q, pend_sl_q, pend_sh_q;
  logic                      pend_ovf_q;
  nop_pkg::out_item_t        out_q;

  assign out_free    = ~out_vld_q | note_o.ready;
  assign move        = pend_q & out_free;
  assign evt_i.ready = ~pend_q & out_free;

  assign pend_d    = emit | (pend_q & ~move);
  assign out_vld_d = move | (out_vld_q & ~note_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pend_slot_q <= found;
      pend_end_q  <= clk_new;
      pend_tl_q   <= tl_d;
      pend_th_q   <= th_d;
      pend_sl_q   <= sl_d;
      pend_sh_q   <= sh_d;
      pend_ovf_q  <= ovf_q;
    end
    if (move) begin
      out_q.done_key       <= pend_slot_q.key;
      out_q.done_velocity  <= pend_slot_q.velocity;
      out_q.start_tick     <= pend_slot_q.start;
      out_q.length_ticks   <= pend_end_q - pend_slot_q.start;
      out_q.track_lowest   <= pend_tl_q;
      out_q.track_highest  <= pend_th_q;
      out_q.song_lowest    <= pend_sl_q;
      out_q.song_highest   <= pend_sh_q;
      out_q.table_overflow <= pend_ovf_q;
    end
  end

  assign note_o.valid = out_vld_q;
  assign note_o.data  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_accept_while_pending : assert property (
    @(posedge clk_i) disable iff (!rst_ni) acc |-> !pend_q)
    else $error("event taken while a note is pending");

  a_table_packed : assert property (
    @(posedge clk_i) disable iff (!rst_ni) ((used_vec >> 1) & ~used_vec) == '0)
    else $error("slot table has a gap");

  a_overflow_sticky : assert property (
    @(posedge clk_i) disable iff (!rst_ni) ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

  a_match_pends : assert property (
    @(posedge clk_i) disable iff (!rst_ni) emit |=> pend_q)
    else $error("matched note-off lost");

  a_extremes_bracket : assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_vld_q |->
      (out_q.track_lowest <= out_q.done_key) && (out_q.done_key <= out_q.track_highest) &&
      (out_q.song_lowest <= out_q.done_key) && (out_q.done_key <= out_q.song_highest))
    else $error("key extremes do not bracket the note");

endmodule
